FILE: src/hu8_pkg.sv
package hu8_pkg;

	localparam int CAP_W        = 11;
	localparam int UNIT_W       = 16;
	localparam int BUNDLE_BYTES = 5;
	localparam int BCNT_W       = 3;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [CAP_W-1:0]  CAP_RESET = 11'd64;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;

	localparam logic [UNIT_W-1:0] LIM_1B   = 16'h007F;
	localparam logic [UNIT_W-1:0] LIM_2B   = 16'h07FF;
	localparam logic [UNIT_W-1:0] LIM_3B   = 16'hD7FF;
	localparam logic [UNIT_W-1:0] LIM_LEAD = 16'hF8FF;
	localparam logic [UNIT_W-1:0] LEAD_ADJ = 16'h0040;

	localparam logic [7:0] PFX_2B   = 8'hC0;
	localparam logic [7:0] PFX_3B   = 8'hE0;
	localparam logic [7:0] PFX_4B   = 8'hF0;
	localparam logic [7:0] PFX_CONT = 8'h80;

	// Up to five bytes made by one character; a terminator, when present,
	// is the last byte and reads zero.
	typedef struct packed {
		logic [BUNDLE_BYTES-1:0][7:0] bytes;
		logic [BCNT_W-1:0]            count;
		logic                         term;
	} hu8_bundle_t;

	typedef struct packed {
		logic        valid;
		hu8_bundle_t bnd;
	} hu8_push_t;

	function automatic logic [UNIT_W-1:0] hex_value(input logic [7:0] c);
		logic [UNIT_W-1:0] d;
		begin
			if (c >= CHAR_LC_A) begin
				d = {8'h00, c} - 16'd87;
			end else if (c >= CHAR_UC_A) begin
				d = {8'h00, c} - 16'd55;
			end else begin
				d = {8'h00, c} - 16'd48;
			end
			return d;
		end
	endfunction

endpackage

FILE: src/hu8_ifs.sv
interface hu8_in_if import hu8_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] src_char;
	logic       string_start;

	modport source(output valid, output src_char, output string_start, input ready);
	modport sink(input valid, input src_char, input string_start, output ready);
endinterface

interface hu8_out_if import hu8_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_last;

	modport source(output valid, output out_byte, output is_last, input ready);
	modport sink(input valid, input out_byte, input is_last, output ready);
endinterface

FILE: src/hex_ucs2_to_utf8_core.sv
// Hex UCS-2 to UTF-8 converter. Takes one hex character per beat on src
// (string_start marks the first character of a string) and returns UTF-8
// bytes on dst, closing every string with a zero byte flagged is_last. The
// output budget out_capacity (bytes, including the zero) is written through
// cfg_we/cfg_wdata, by the user only while idle (not enforced by the block),
// and is sampled at each string start. Rate: one character is accepted and
// one byte leaves every cycle; a character passes through the input register
// before its bytes enter a queue of QUEUE_DEPTH byte groups (up to five
// bytes each). src.ready drops only when the queue lacks a slot for the
// character in flight plus a new one. Input stalls when dst stalls, or when
// multi-byte groups land close together: the queue counts groups but drains
// only one byte per cycle, so a four- or five-byte group followed by groups
// on the next characters fills it before the long group has left.
module hex_ucs2_to_utf8_core import hu8_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	hu8_in_if.sink           src,
	hu8_out_if.source        dst
);

	localparam int LVL_W = $clog2(QUEUE_DEPTH_P+1);

	logic             take;
	logic             busy;
	hu8_push_t        push;
	logic [LVL_W-1:0] level;
	logic [LVL_W:0]   claimed;

	// Count the slot that the character in the input register may still need.
	assign claimed   = {1'b0, level} + (LVL_W+1)'(busy);
	assign src.ready = (claimed < (LVL_W+1)'(QUEUE_DEPTH_P));
	assign take      = src.valid && src.ready;

	hu8_encode u_encode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.char_in   (src.src_char),
		.start_in  (src.string_start),
		.busy      (busy),
		.push      (push)
	);

	hu8_drain #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_drain (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.level  (level),
		.dst    (dst)
	);

`ifndef SYNTHESIS
	// The queue must have room whenever a byte group is pushed.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> level < LVL_W'(QUEUE_DEPTH_P))
		else $error("byte group pushed into a full queue");

	// A pushed group holds between one and five bytes.
	a_group_size: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (push.bnd.count != '0 && push.bnd.count <= BCNT_W'(BUNDLE_BYTES)))
		else $error("byte group size out of range");

	// The terminator beat always carries a zero byte.
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dst.valid && dst.is_last) |-> dst.out_byte == 8'h00)
		else $error("terminator beat with a nonzero byte");
`endif

endmodule

FILE: src/hu8_encode.sv
module hu8_encode import hu8_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             take,
	input  logic [7:0]       char_in,
	input  logic             start_in,
	output logic             busy,
	output hu8_push_t        push
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             start_s1;

	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  budget_q, budget_d;
	logic [UNIT_W-1:0] acc_q, acc_d;
	logic [1:0]        cnt_q, cnt_d;
	logic [UNIT_W-1:0] lead_q, lead_d;
	logic              trail_q, trail_d;
	logic              first_q, first_d;
	logic              fin_q, fin_d;

	logic [BUNDLE_BYTES-1:0][7:0] e;
	logic [BCNT_W-1:0]            en;
	logic                         term;

	always_comb begin
		logic              go;
		logic [UNIT_W-1:0] v;
		logic [UNIT_W-1:0] h;
		budget_d = budget_q;
		acc_d    = acc_q;
		cnt_d    = cnt_q;
		lead_d   = lead_q;
		trail_d  = trail_q;
		first_d  = first_q;
		fin_d    = fin_q;
		e        = '0;
		en       = '0;
		term     = 1'b0;
		v        = '0;
		h        = lead_q;
		go       = 1'b1;

		// A start resets the string; a capacity of zero or one closes it at once.
		if (start_s1) begin
			budget_d = cap_q;
			acc_d    = '0;
			cnt_d    = '0;
			lead_d   = '0;
			trail_d  = 1'b0;
			first_d  = 1'b1;
			fin_d    = 1'b0;
			if (cap_q <= CAP_W'(1)) begin
				term  = 1'b1;
				fin_d = 1'b1;
				go    = 1'b0;
			end
		end
		if (go && fin_d) begin
			go = 1'b0;
		end
		if (go && first_d) begin
			first_d = 1'b0;
			if (char_s1 == CHAR_QUOTE) begin
				go = 1'b0;
			end
		end
		if (go && !trail_d && cnt_d == 2'd0 &&
		    (char_s1 == CHAR_NUL || char_s1 == CHAR_QUOTE)) begin
			term  = 1'b1;
			fin_d = 1'b1;
			go    = 1'b0;
		end
		if (go) begin
			acc_d = {acc_d[UNIT_W-5:0], 4'h0} + hex_value(char_s1);
			cnt_d = cnt_d + 2'd1;
			if (cnt_d != 2'd0) begin
				go = 1'b0;
			end
		end
		if (go) begin
			v     = acc_d;
			acc_d = '0;
			h     = lead_d;
			if (trail_d) begin
				trail_d  = 1'b0;
				e[0]     = PFX_4B   | {5'd0, h[10:8]};
				e[1]     = PFX_CONT | {2'd0, h[7:2]};
				e[2]     = PFX_CONT | {2'd0, h[1:0], v[9:6]};
				e[3]     = PFX_CONT | {2'd0, v[5:0]};
				en       = BCNT_W'(4);
				budget_d = budget_d - CAP_W'(4);
			end else if (v <= LIM_1B) begin
				e[0]     = v[7:0];
				en       = BCNT_W'(1);
				budget_d = budget_d - CAP_W'(1);
			end else if (v <= LIM_2B) begin
				if (budget_d < CAP_W'(3)) begin
					term  = 1'b1;
					fin_d = 1'b1;
				end else begin
					e[0]     = PFX_2B   | {3'd0, v[10:6]};
					e[1]     = PFX_CONT | {2'd0, v[5:0]};
					en       = BCNT_W'(2);
					budget_d = budget_d - CAP_W'(2);
				end
			end else if (v <= LIM_3B) begin
				if (budget_d < CAP_W'(4)) begin
					term  = 1'b1;
					fin_d = 1'b1;
				end else begin
					e[0]     = PFX_3B   | {4'd0, v[15:12]};
					e[1]     = PFX_CONT | {2'd0, v[11:6]};
					e[2]     = PFX_CONT | {2'd0, v[5:0]};
					en       = BCNT_W'(3);
					budget_d = budget_d - CAP_W'(3);
				end
			end else if (v <= LIM_LEAD) begin
				if (budget_d < CAP_W'(5)) begin
					term  = 1'b1;
					fin_d = 1'b1;
				end else begin
					lead_d  = v + LEAD_ADJ;
					trail_d = 1'b1;
				end
			end else begin
				e[0]     = CHAR_SPACE;
				en       = BCNT_W'(1);
				budget_d = budget_d - CAP_W'(1);
			end
			// Close as soon as only the terminator's byte is left.
			if (!fin_d && budget_d <= CAP_W'(1)) begin
				term  = 1'b1;
				fin_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cap_q    <= CAP_RESET;
			budget_q <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			lead_q   <= '0;
			trail_q  <= 1'b0;
			first_q  <= 1'b0;
			fin_q    <= 1'b1;
		end else begin
			valid_s1 <= take;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (valid_s1) begin
				budget_q <= budget_d;
				acc_q    <= acc_d;
				cnt_q    <= cnt_d;
				lead_q   <= lead_d;
				trail_q  <= trail_d;
				first_q  <= first_d;
				fin_q    <= fin_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1  <= char_in;
			start_s1 <= start_in;
		end
	end

	assign busy            = valid_s1;
	assign push.valid      = valid_s1 && (en != '0 || term);
	assign push.bnd.bytes  = e;
	assign push.bnd.count  = en + BCNT_W'(term);
	assign push.bnd.term   = term;

endmodule

FILE: src/hu8_drain.sv
module hu8_drain import hu8_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hu8_push_t                  push,
	output logic [$clog2(DEPTH+1)-1:0] level,
	hu8_out_if.source                  dst
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH+1);

	hu8_bundle_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic [BCNT_W-1:0] idx_q;

	hu8_bundle_t head;
	logic        beat;
	logic        at_end;
	logic        pop;

	assign head   = mem_q[rd_ptr_q];
	assign beat   = dst.valid && dst.ready;
	assign at_end = (idx_q == head.count - BCNT_W'(1));
	assign pop    = beat && at_end;

	assign dst.valid    = (level_q != '0);
	assign dst.out_byte = head.bytes[idx_q];
	assign dst.is_last  = head.term && at_end;
	assign level        = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			// Advance within the bundle; drop it after its last beat.
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
				idx_q    <= '0;
			end else if (beat) begin
				idx_q <= idx_q + BCNT_W'(1);
			end
			level_q <= level_q + LVL_W'(push.valid) - LVL_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.bnd;
		end
	end

endmodule
